/* rtl/core/pfa_pkg.sv */
// Shared types and constants of the page-frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

    // Default sizes, handed down through the top-level parameters.
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed field widths of the streams.
    localparam int ACT_W  = 3;
    localparam int PAGE_W = 16;
    localparam int ST_W   = 3;
    localparam int RC_W   = 8;
    localparam int FC_W   = 17;
    localparam int LOW_W  = 16;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 3'd0,
        ACT_FREE    = 3'd1,
        ACT_REF_INC = 3'd2,
        ACT_REF_DEC = 3'd3,
        ACT_READ    = 3'd4
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_LIMIT   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Control outcome of one executed request.
    typedef struct packed {
        t_status status;
        logic    cnt_we;
        logic    push;
        logic    pop;
        logic    returned;
    } t_exec_ctl;

endpackage

/* rtl/core/pfa_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pfa_exec.sv */
// Request decode and count update for one allocator request.
`timescale 1ns / 1ps

module pfa_exec #(
    parameter int NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF,
    parameter int PG_W       = $clog2(NUM_PAGES),
    parameter int DEPTH_W    = $clog2(NUM_PAGES + 1)
) (
    input  logic [pfa_pkg::ACT_W-1:0]  i_action,
    input  logic [pfa_pkg::PAGE_W-1:0] i_page,
    input  logic [pfa_pkg::LOW_W-1:0]  i_lowest,
    input  logic [DEPTH_W-1:0]         i_depth,
    input  logic [COUNT_BITS-1:0]      i_cnt,
    input  logic [PG_W-1:0]            i_stack_pg,
    output pfa_pkg::t_exec_ctl         o_ctl,
    output logic [PG_W-1:0]            o_cnt_addr,
    output logic [COUNT_BITS-1:0]      o_cnt_data,
    output logic [pfa_pkg::RC_W-1:0]   o_ref_count,
    output logic [pfa_pkg::PAGE_W-1:0] o_result_page
);
    import pfa_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                       page_ok;
    logic [COUNT_BITS-1:0]      ref_cnt;
    logic [COUNT_BITS+RC_W-1:0] ref_wide;
    logic [PG_W+PAGE_W-1:0]     pop_wide;

    assign page_ok = (i_page >= i_lowest)
                  && ({1'b0, i_page} < (PAGE_W + 1)'(NUM_PAGES));
    assign pop_wide = {{PAGE_W{1'b0}}, i_stack_pg};
    assign ref_wide = {{RC_W{1'b0}}, ref_cnt};
    assign o_ref_count = ref_wide[RC_W-1:0];

    always_comb begin
        o_ctl         = '0;
        o_ctl.status  = ST_INVALID;
        o_cnt_addr    = i_page[PG_W-1:0];
        o_cnt_data    = '0;
        o_result_page = '0;
        ref_cnt       = '0;
        if (i_action == ACT_ALLOC) begin
            if (i_depth == '0) begin
                o_ctl.status = ST_EMPTY;
            end else begin
                // Pop the most recently freed page and give it one reference.
                o_ctl.status  = ST_OK;
                o_ctl.pop     = 1'b1;
                o_ctl.cnt_we  = 1'b1;
                o_cnt_addr    = i_stack_pg;
                o_cnt_data    = COUNT_BITS'(1);
                ref_cnt       = COUNT_BITS'(1);
                o_result_page = pop_wide[PAGE_W-1:0];
            end
        end else if (page_ok) begin
            unique case (i_action)
                ACT_FREE: begin
                    if (i_cnt > COUNT_BITS'(1)) begin
                        o_ctl.status  = ST_OK;
                        o_ctl.cnt_we  = 1'b1;
                        o_cnt_data    = i_cnt - COUNT_BITS'(1);
                        ref_cnt       = i_cnt - COUNT_BITS'(1);
                        o_result_page = i_page;
                    end else if (i_depth >= DEPTH_W'(NUM_PAGES)) begin
                        o_ctl.status = ST_FULL;
                        ref_cnt      = i_cnt;
                    end else begin
                        o_ctl.status   = ST_OK;
                        o_ctl.cnt_we   = 1'b1;
                        o_ctl.push     = 1'b1;
                        o_ctl.returned = 1'b1;
                        o_result_page  = i_page;
                    end
                end
                ACT_REF_INC: begin
                    if (i_cnt == COUNT_MAX) begin
                        o_ctl.status = ST_LIMIT;
                        ref_cnt      = i_cnt;
                    end else begin
                        o_ctl.status  = ST_OK;
                        o_ctl.cnt_we  = 1'b1;
                        o_cnt_data    = i_cnt + COUNT_BITS'(1);
                        ref_cnt       = i_cnt + COUNT_BITS'(1);
                        o_result_page = i_page;
                    end
                end
                ACT_REF_DEC: begin
                    if (i_cnt == '0) begin
                        o_ctl.status = ST_LIMIT;
                    end else begin
                        o_ctl.status  = ST_OK;
                        o_ctl.cnt_we  = 1'b1;
                        o_cnt_data    = i_cnt - COUNT_BITS'(1);
                        ref_cnt       = i_cnt - COUNT_BITS'(1);
                        o_result_page = i_page;
                    end
                end
                ACT_READ: begin
                    o_ctl.status  = ST_OK;
                    ref_cnt       = i_cnt;
                    o_result_page = i_page;
                end
                default: begin
                    o_ctl.status = ST_INVALID;
                end
            endcase
        end
    end

endmodule

/* rtl/core/page_frame_allocator_refcount_unit.sv */
// Top level of the page-frame allocator with per-page reference counts.
`timescale 1ns / 1ps

// Physical page-frame allocator with a LIFO free stack and a reference count
// for every page. Each request on the input stream carries an action (alloc,
// free, ref_inc, ref_dec, read) and a page number, and produces exactly one
// result transfer with a status, the page, its count after the request, the
// number of free pages and a flag that a free returned the page to the pool.
// In the cycle of a request's transfer the count memory and the free stack
// are read; in the execute state that follows, the registered read data is
// evaluated, both memories are written back and the result is loaded into
// the output register. Since the write-back lands before the next read is
// issued, back-to-back requests see each other's updates without
// forwarding. The output register lets the next request be taken while a
// result still waits; a request only stalls in the execute state when the
// previous result has not been taken yet. After reset the count memory is
// cleared one entry per cycle; no request is taken during that pass, while
// writes of lowest_page are taken at any time. The free stack needs no
// clearing since only entries below its depth are read. lowest_page must
// only be written while the block is idle.
module page_frame_allocator_refcount_unit #(
    parameter int NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration: lowest_page.
    input  logic                           i_cfg_wr_en,
    input  logic [pfa_pkg::LOW_W-1:0]      i_cfg_wr_data,
    // Requests.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: action[2:0], page[18:3], zero fill[23:19].
    input  logic [pfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Results.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: status[2:0], result_page[18:3], ref_count[26:19],
    // free_count[43:27], returned_to_pool[44], zero fill[47:45].
    output logic [pfa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pfa_pkg::*;

    localparam int PG_W    = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [ACT_W-1:0]      r_action;
    logic [PAGE_W-1:0]     r_page;
    logic [LOW_W-1:0]      r_lowest;
    logic [DEPTH_W-1:0]    r_depth, n_depth;
    logic [PG_W-1:0]       r_clr_addr;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  in_xfer;
    logic                  ex_go;
    logic [DEPTH_W-1:0]    depth_dec;

    t_exec_ctl             ex_ctl;
    logic [PG_W-1:0]       ex_cnt_addr;
    logic [COUNT_BITS-1:0] ex_cnt_data;
    logic [RC_W-1:0]       ex_ref_count;
    logic [PAGE_W-1:0]     ex_result_page;

    logic                  cnt_we;
    logic [PG_W-1:0]       cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [PG_W-1:0]       stk_rdata;

    logic [FC_W+DEPTH_W-1:0] fc_wide;

    // A request is taken only in the idle state; the result register is
    // checked in the execute cycle, so a waiting result does not block this.
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign ex_go         = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign depth_dec     = r_depth - DEPTH_W'(1);

    // Count memory: written by the clearing pass, then by executed requests.
    always_comb begin
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_addr;
            cnt_wdata = '0;
        end else begin
            cnt_we    = ex_go && ex_ctl.cnt_we;
            cnt_waddr = ex_cnt_addr;
            cnt_wdata = ex_cnt_data;
        end
    end

    pfa_ram #(
        .W     (COUNT_BITS),
        .DEPTH (NUM_PAGES),
        .AW    (PG_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (in_xfer),
        .i_raddr (s_axis_tdata[ACT_W +: PG_W]),
        .o_rdata (cnt_rdata)
    );

    // Free stack: the top entry is read speculatively with every request and
    // only used by an alloc; a push writes at the current depth.
    pfa_ram #(
        .W     (PG_W),
        .DEPTH (NUM_PAGES),
        .AW    (PG_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ex_go && ex_ctl.push),
        .i_waddr (r_depth[PG_W-1:0]),
        .i_wdata (r_page[PG_W-1:0]),
        .i_re    (in_xfer),
        .i_raddr (depth_dec[PG_W-1:0]),
        .o_rdata (stk_rdata)
    );

    pfa_exec #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS),
        .PG_W       (PG_W),
        .DEPTH_W    (DEPTH_W)
    ) u_exec (
        .i_action      (r_action),
        .i_page        (r_page),
        .i_lowest      (r_lowest),
        .i_depth       (r_depth),
        .i_cnt         (cnt_rdata),
        .i_stack_pg    (stk_rdata),
        .o_ctl         (ex_ctl),
        .o_cnt_addr    (ex_cnt_addr),
        .o_cnt_data    (ex_cnt_data),
        .o_ref_count   (ex_ref_count),
        .o_result_page (ex_result_page)
    );

    // Stack depth after the request; free_count reports this value.
    always_comb begin
        priority if (ex_ctl.pop) begin
            n_depth = depth_dec;
        end else if (ex_ctl.push) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else begin
            n_depth = r_depth;
        end
    end

    assign fc_wide    = {{FC_W{1'b0}}, n_depth};
    assign n_out_data = {3'b000, ex_ctl.returned, fc_wide[FC_W-1:0], ex_ref_count,
                         ex_result_page, ex_ctl.status};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == PG_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ex_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_depth     <= '0;
            r_lowest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + PG_W'(1);
            end
            if (i_cfg_wr_en) begin
                r_lowest <= i_cfg_wr_data;
            end
            if (ex_go) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= s_axis_tdata[ACT_W-1:0];
            r_page   <= s_axis_tdata[ACT_W +: PAGE_W];
        end
        if (ex_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The stack never holds more entries than there are pages.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(NUM_PAGES))
        else $error("free stack depth above page count");

    // No request is taken while the count memory is being cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    // A taken request puts the block into the execute state in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EXEC))
        else $error("request not executed after transfer");

    // A page returned to the pool raises the depth by exactly one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_go && ex_ctl.returned) |=> (r_depth == $past(r_depth) + DEPTH_W'(1)))
        else $error("push did not raise stack depth");

    // An executed request always leaves a result in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_go |=> m_axis_tvalid)
        else $error("executed request left no result");

endmodule
